// File: rtl/hsl_to_rgb_converter_unit_defines.svh
`ifndef HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Check that holds on every clock edge outside reset.
`define HSL2RGB_ASSERT_ALWAYS(name, ck, rn, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("hsl2rgb check failed");

// Implication check; cons may be a sequence.
`define HSL2RGB_ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) \
        else $error("hsl2rgb check failed");

`endif

// File: rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    localparam int Q_W = 13;

    typedef logic [Q_W-1:0] q12_t;

    localparam q12_t ONE_Q12        = 13'd4096;
    localparam q12_t THIRD_Q12      = 13'd1365;
    localparam q12_t SIXTH_Q12      = 13'd683;
    localparam q12_t HALF_Q12       = 13'd2048;
    localparam q12_t TWO_THIRDS_Q12 = 13'd2731;

    // hue ramp segment
    typedef logic [1:0] seg_t;
    localparam seg_t SEG_RISE = 2'd0;
    localparam seg_t SEG_HIGH = 2'd1;
    localparam seg_t SEG_FALL = 2'd2;
    localparam seg_t SEG_LOW  = 2'd3;

    typedef struct packed {
        q12_t factor;
        seg_t seg;
    } chan_t;

    typedef struct packed {
        q12_t  p;
        q12_t  q;
        q12_t  span;
        chan_t red;
        chan_t green;
        chan_t blue;
    } qp_beat_t;

endpackage

// File: rtl/hsl_to_rgb_converter_unit.sv
// HSL to RGB pixel converter, fully pipelined.
// done and the pixel pass through stages 1-3 in hsl2rgb_qp, stages 4-5 in hsl2rgb_ramp, then the output registers.
// Throughput: one pixel per clock; busy is always low, every pipe stage advances each cycle.
// Results are not held: the receiver takes each beat in the cycle done is high.
// rst_n (async, active low) clears all valid bits; in-flight pixels are dropped.
module hsl_to_rgb_converter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  hsl2rgb_pkg::q12_t   hue,
    input  hsl2rgb_pkg::q12_t   saturation,
    input  hsl2rgb_pkg::q12_t   lightness,
    output logic                done,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue
);
    import hsl2rgb_pkg::*;

    logic     qp_valid;
    qp_beat_t qp_beat;
    logic     r_valid, g_valid, b_valid;
    q12_t     r_value, g_value, b_value;

    logic       done_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic [7:0] red_next, green_next, blue_next;

    function automatic logic [7:0] to_byte(input q12_t v);
        logic [20:0] m;
        m = {v, 8'b0} - {8'b0, v};
        return m[19:12];
    endfunction

    hsl2rgb_qp u_qp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start & ~busy),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (qp_valid),
        .out_beat   (qp_beat)
    );

    hsl2rgb_ramp u_ramp_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qp_valid),
        .p         (qp_beat.p),
        .q         (qp_beat.q),
        .span      (qp_beat.span),
        .chan      (qp_beat.red),
        .out_valid (r_valid),
        .value     (r_value)
    );

    hsl2rgb_ramp u_ramp_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qp_valid),
        .p         (qp_beat.p),
        .q         (qp_beat.q),
        .span      (qp_beat.span),
        .chan      (qp_beat.green),
        .out_valid (g_valid),
        .value     (g_value)
    );

    hsl2rgb_ramp u_ramp_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qp_valid),
        .p         (qp_beat.p),
        .q         (qp_beat.q),
        .span      (qp_beat.span),
        .chan      (qp_beat.blue),
        .out_valid (b_valid),
        .value     (b_value)
    );

    assign red_next   = to_byte(r_value);
    assign green_next = to_byte(g_value);
    assign blue_next  = to_byte(b_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_valid & g_valid & b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: rtl/hsl2rgb_qp.sv
module hsl2rgb_qp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  hsl2rgb_pkg::q12_t    hue,
    input  hsl2rgb_pkg::q12_t    saturation,
    input  hsl2rgb_pkg::q12_t    lightness,
    output logic                 out_valid,
    output hsl2rgb_pkg::qp_beat_t out_beat
);
    import hsl2rgb_pkg::*;

    localparam logic [13:0] RAMP_SLOPE = 14'd6;

    function automatic q12_t clamp_one(input q12_t v);
        return (v > ONE_Q12) ? ONE_Q12 : v;
    endfunction

    // t is a wrapped hue, 0..4096
    function automatic chan_t ramp_sel(input logic [13:0] t);
        chan_t       c;
        logic [13:0] d;
        d        = 14'(TWO_THIRDS_Q12) - t;
        c.factor = '0;
        c.seg    = SEG_LOW;
        if (t < 14'(SIXTH_Q12))
        begin
            c.seg    = SEG_RISE;
            c.factor = 13'(t * RAMP_SLOPE);
        end
        else if (t < 14'(HALF_Q12))
        begin
            c.seg = SEG_HIGH;
        end
        else if (t < 14'(TWO_THIRDS_Q12))
        begin
            c.seg    = SEG_FALL;
            c.factor = 13'(d * RAMP_SLOPE);
        end
        return c;
    endfunction

    // stage 1: clamped inputs
    logic v1_reg;
    q12_t h1_reg, s1_reg, l1_reg;
    // stage 2: l * s
    logic        v2_reg;
    q12_t        h2_reg, s2_reg, l2_reg;
    logic [24:0] ls2_reg;
    logic [24:0] ls2_next;
    // stage 3: q, p, ramp selects
    logic     v3_reg;
    qp_beat_t beat3_reg;
    qp_beat_t beat3_next;

    q12_t        ph;
    q12_t        dq;
    logic [13:0] t_red, t_green, t_blue;
    logic [13:0] h_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h1_reg    <= clamp_one(hue);
        s1_reg    <= clamp_one(saturation);
        l1_reg    <= clamp_one(lightness);
        h2_reg    <= h1_reg;
        s2_reg    <= s1_reg;
        l2_reg    <= l1_reg;
        ls2_reg   <= ls2_next;
        beat3_reg <= beat3_next;
    end

    assign ls2_next = {12'b0, l1_reg} * {12'b0, s1_reg};

    always_comb
    begin
        ph = ls2_reg[24:12];
        // q - l; q = l + dq and p = l - dq, so zero saturation gives p = q = l
        dq = (l2_reg < HALF_Q12) ? ph : (s2_reg - ph);
        beat3_next.q    = l2_reg + dq;
        beat3_next.p    = l2_reg - dq;
        beat3_next.span = {dq[11:0], 1'b0};

        h_plus  = {1'b0, h2_reg} + 14'(THIRD_Q12);
        t_red   = (h_plus > 14'(ONE_Q12)) ? (h_plus - 14'(ONE_Q12)) : h_plus;
        t_green = {1'b0, h2_reg};
        t_blue  = (h2_reg < THIRD_Q12)
                ? ({1'b0, h2_reg} + 14'(ONE_Q12) - 14'(THIRD_Q12))
                : ({1'b0, h2_reg} - 14'(THIRD_Q12));

        beat3_next.red   = ramp_sel(t_red);
        beat3_next.green = ramp_sel(t_green);
        beat3_next.blue  = ramp_sel(t_blue);
    end

    assign out_valid = v3_reg;
    assign out_beat  = beat3_reg;

endmodule

// File: rtl/hsl2rgb_ramp.sv
module hsl2rgb_ramp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hsl2rgb_pkg::q12_t   p,
    input  hsl2rgb_pkg::q12_t   q,
    input  hsl2rgb_pkg::q12_t   span,
    input  hsl2rgb_pkg::chan_t  chan,
    output logic                out_valid,
    output hsl2rgb_pkg::q12_t   value
);
    import hsl2rgb_pkg::*;

    // stage 4: span * factor
    logic        v4_reg;
    logic [25:0] prod4_reg;
    logic [25:0] prod4_next;
    seg_t        seg4_reg;
    q12_t        p4_reg, q4_reg, span4_reg;
    // stage 5: channel value
    logic        v5_reg;
    q12_t        value5_reg;
    q12_t        value5_next;

    logic [13:0] x;
    q12_t        lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod4_reg  <= prod4_next;
        seg4_reg   <= chan.seg;
        p4_reg     <= p;
        q4_reg     <= q;
        span4_reg  <= span;
        value5_reg <= value5_next;
    end

    assign prod4_next = {13'b0, span} * {13'b0, chan.factor};

    always_comb
    begin
        x = prod4_reg[25:12];
        // falling edge factor can overshoot by a hair; cap at q
        lim = (x > {1'b0, span4_reg}) ? span4_reg : x[12:0];
        case (seg4_reg) inside
            SEG_RISE, SEG_FALL: value5_next = p4_reg + lim;
            SEG_HIGH:           value5_next = q4_reg;
            default:            value5_next = p4_reg;
        endcase
    end

    assign out_valid = v5_reg;
    assign value     = value5_reg;

endmodule

// File: rtl/hsl2rgb_checker.sv
`include "hsl_to_rgb_converter_unit_defines.svh"

module hsl2rgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [12:0] saturation,
    input logic [12:0] lightness,
    input logic        done,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);

    `HSL2RGB_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

    `HSL2RGB_ASSERT_IMPLY(a_latency, clk, rst_n, start && !busy, ##6 done)

    `HSL2RGB_ASSERT_IMPLY(a_no_spurious, clk, rst_n, done, $past(start && !busy, 6))

    `HSL2RGB_ASSERT_IMPLY(a_gray, clk, rst_n,
        done && $past(start && !busy && saturation == 13'd0, 6),
        red == green && green == blue)

    `HSL2RGB_ASSERT_IMPLY(a_black, clk, rst_n,
        done && $past(start && !busy && lightness == 13'd0, 6),
        red == 8'd0 && green == 8'd0 && blue == 8'd0)

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_hsl2rgb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .saturation (saturation),
    .lightness  (lightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
);
